@@ hdl/mbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mbc_pkg: shared types and constants for the multiplicative byte cipher
// Holds the configuration register map, reset values, field widths and the
// item that moves from the front end to the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mbc_pkg;

  // key store depth default
  localparam int KeyDepthDefault = 32;

  // small decoupling queue between front and back
  localparam int QueueDepth = 2;

  // configuration register map
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_DIRECTION  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODULUS    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LENGTH = 2'd2;

  // register widths and reset values
  localparam int ModW = 9;
  localparam int LenW = 6;
  localparam logic            DirReset = 1'b0;
  localparam logic [ModW-1:0] ModReset = 9'd257;
  localparam logic [LenW-1:0] LenReset = 6'd32;

  // effective modulus: a zero register means 512
  localparam int EffModW = 10;
  localparam logic [EffModW-1:0] ModZeroValue = 10'd512;

  // direction codes
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  // input op codes
  localparam logic OP_KEY_WRITE = 1'b0;
  localparam logic OP_DATA      = 1'b1;

  // stream widths
  localparam int KeyIdxW = 5;
  localparam int ByteW = 8;
  localparam int InDataW = 16;   // key_index, value, zero pad
  localparam int InUserW = 2;    // op, first
  localparam int OutDataW = 8;   // result_byte
  localparam int OutUserW = 1;   // not_invertible

  // one data byte with its key byte, front to back
  typedef struct packed {
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] key;
  } mbc_item_t;

endpackage

`default_nettype wire

@@ hdl/mbc_queue.sv @@
// ----------------------------------------------------------------------------
// mbc_queue: short FIFO between the front end and the back end
// Two entries of data byte plus key byte; push and pop may happen together.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire mbc_pkg::mbc_item_t push_item,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output mbc_pkg::mbc_item_t     pop_item
);

  localparam int Depth = mbc_pkg::QueueDepth;
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  mbc_pkg::mbc_item_t entry_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign push_ready = (count_r != CntW'(Depth));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mbc_front.sv @@
// ----------------------------------------------------------------------------
// mbc_front: input side of the cipher
// Takes key writes into the key store, tracks the key position and looks up
// the key byte for each data byte, then hands byte and key to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc_front #(
  parameter int KEY_DEPTH = mbc_pkg::KeyDepthDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [mbc_pkg::LenW-1:0]      key_length,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic                          in_first,
  input  wire logic [mbc_pkg::KeyIdxW-1:0]   in_key_index,
  input  wire logic [mbc_pkg::ByteW-1:0]     in_value,
  output logic                               q_valid,
  input  wire logic                          q_ready,
  output mbc_pkg::mbc_item_t                 q_item
);

  localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW = $clog2(KEY_DEPTH + 1);
  localparam int CW = (LW > mbc_pkg::LenW) ? LW : mbc_pkg::LenW;
  localparam logic WR_ALL = (KEY_DEPTH >= (1 << mbc_pkg::KeyIdxW));

  logic [mbc_pkg::ByteW-1:0] key_mem [KEY_DEPTH];

  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] pos_base, pos_use;
  logic [LW-1:0] eff_len, pos_inc;
  logic [CW-1:0] len_wide;
  logic          stage_valid_r, stage_valid_nxt;
  logic [mbc_pkg::ByteW-1:0] stage_value_r;
  logic [mbc_pkg::ByteW-1:0] key_rd_r;
  logic          accept, acc_data, acc_key, key_in_range;

  assign in_ready = !stage_valid_r || q_ready;
  assign accept   = in_valid && in_ready;
  assign acc_data = accept && (in_op == mbc_pkg::OP_DATA);
  assign acc_key  = accept && (in_op == mbc_pkg::OP_KEY_WRITE);

  // a write beyond the store is dropped
  assign key_in_range = WR_ALL || (in_key_index < mbc_pkg::KeyIdxW'(KEY_DEPTH));

  // effective key length: zero acts as one, clipped to the store depth
  assign len_wide = CW'(key_length);
  always_comb begin
    if (key_length == '0) begin
      eff_len = LW'(1);
    end else if (len_wide > CW'(KEY_DEPTH)) begin
      eff_len = LW'(KEY_DEPTH);
    end else begin
      eff_len = LW'(key_length);
    end
  end

  // key position for this beat and the one after
  always_comb begin
    pos_base = in_first ? '0 : pos_r;
    pos_use  = (LW'(pos_base) < eff_len) ? pos_base : '0;
    pos_inc  = LW'(pos_use) + 1'b1;
    pos_nxt  = (pos_inc == eff_len) ? '0 : AW'(pos_inc);
  end

  // lookup stage: holds one byte until the queue takes it
  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (acc_data) begin
      stage_valid_nxt = 1'b1;
    end else if (q_ready) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      if (acc_data) begin
        pos_r <= pos_nxt;
      end
    end
  end

  // key store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (acc_key && key_in_range) begin
      key_mem[AW'(in_key_index)] <= in_value;
    end
    if (acc_data) begin
      key_rd_r      <= key_mem[pos_use];
      stage_value_r <= in_value;
    end
  end

  assign q_valid      = stage_valid_r;
  assign q_item.value = stage_value_r;
  assign q_item.key   = key_rd_r;

endmodule

`default_nettype wire

@@ hdl/mbc_back.sv @@
// ----------------------------------------------------------------------------
// mbc_back: arithmetic engine of the cipher
// Finds the key inverse by extended Euclid (one quotient bit a cycle), forms
// the byte product and reduces it modulo m one bit a cycle, then drives the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbc_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             direction,
  input  wire logic [mbc_pkg::EffModW-1:0]      eff_mod,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire mbc_pkg::mbc_item_t               item,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [mbc_pkg::ByteW-1:0]             out_byte,
  output logic                                  out_bad
);

  localparam int MW = mbc_pkg::EffModW;
  localparam int SW = 13;                       // Bezout coefficient, signed
  localparam int PW = 2 * mbc_pkg::ByteW;       // byte product
  localparam int CntW = $clog2(PW);

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_EUC  = 7'b0000010,
    B_DIV  = 7'b0000100,
    B_UPD  = 7'b0001000,
    B_MUL  = 7'b0010000,
    B_MOD  = 7'b0100000,
    B_OUT  = 7'b1000000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [mbc_pkg::ByteW-1:0] value_r, value_nxt;
  logic [mbc_pkg::ByteW-1:0] mult_r, mult_nxt;
  logic [MW-1:0]             a_r, a_nxt;
  logic [MW-1:0]             b_r, b_nxt;
  logic [MW-1:0]             q_r, q_nxt;
  logic [MW-1:0]             rem_r, rem_nxt;
  logic signed [SW-1:0]      s0_r, s0_nxt;
  logic signed [SW-1:0]      s1_r, s1_nxt;
  logic [PW-1:0]             prod_r, prod_nxt;
  logic [CntW-1:0]           cnt_r, cnt_nxt;
  logic [mbc_pkg::ByteW-1:0] res_r, res_nxt;
  logic                      bad_r, bad_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [mbc_pkg::ByteW-1:0] out_byte_r;
  logic                      out_bad_r;
  logic                      out_load;

  logic [MW:0]               div_trial, mod_trial;
  logic                      div_ge, mod_ge;
  logic signed [SW-1:0]      s1_fix;
  logic signed [SW+MW:0]     qs_prod;

  assign item_ready = (state_r == B_IDLE);
  assign out_load   = (state_r == B_OUT) && (!out_valid_r || out_ready);

  // one long-division step of a by b, and one reduction step of the product
  assign div_trial = {rem_r, a_r[cnt_r]};
  assign div_ge    = (div_trial >= {1'b0, b_r});
  assign mod_trial = {rem_r, prod_r[cnt_r]};
  assign mod_ge    = (mod_trial >= {1'b0, eff_mod});

  // coefficient update and final sign fix
  assign qs_prod = s0_r * $signed({1'b0, q_r});
  always_comb begin
    s1_fix = s1_r;
    if (s1_fix < 0) begin
      s1_fix = s1_r + $signed(SW'(eff_mod));
    end
    if (s1_fix < 0) begin
      s1_fix = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    mult_nxt  = mult_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    prod_nxt  = prod_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    bad_nxt   = bad_r;
    case (state_r)
      B_IDLE: begin
        if (item_valid) begin
          value_nxt = item.value;
          bad_nxt   = 1'b0;
          a_nxt     = MW'(item.key);
          b_nxt     = eff_mod;
          s0_nxt    = '0;
          s1_nxt    = SW'(1);
          if (direction == mbc_pkg::DIR_ENCRYPT) begin
            mult_nxt  = item.key;
            state_nxt = B_MUL;
          end else if (eff_mod == MW'(1)) begin
            mult_nxt  = 8'd1;
            state_nxt = B_MUL;
          end else begin
            state_nxt = B_EUC;
          end
        end
      end
      // loop test of extended Euclid
      B_EUC: begin
        if (a_r > MW'(1)) begin
          if (b_r == '0) begin
            res_nxt   = '0;
            bad_nxt   = 1'b1;
            state_nxt = B_OUT;
          end else begin
            rem_nxt   = '0;
            q_nxt     = '0;
            cnt_nxt   = CntW'(MW - 1);
            state_nxt = B_DIV;
          end
        end else begin
          mult_nxt  = s1_fix[mbc_pkg::ByteW-1:0];
          state_nxt = B_MUL;
        end
      end
      // quotient and remainder, most significant bit first
      B_DIV: begin
        rem_nxt = div_ge ? MW'(div_trial - {1'b0, b_r}) : MW'(div_trial);
        q_nxt   = {q_r[MW-2:0], div_ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = B_UPD;
        end
      end
      B_UPD: begin
        a_nxt     = b_r;
        b_nxt     = rem_r;
        s1_nxt    = s0_r;
        s0_nxt    = s1_r - SW'(qs_prod);
        state_nxt = B_EUC;
      end
      B_MUL: begin
        prod_nxt  = value_r * mult_r;
        rem_nxt   = '0;
        cnt_nxt   = CntW'(PW - 1);
        state_nxt = B_MOD;
      end
      // product mod m, one bit a cycle
      B_MOD: begin
        rem_nxt = mod_ge ? MW'(mod_trial - {1'b0, eff_mod}) : MW'(mod_trial);
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          res_nxt   = rem_nxt[mbc_pkg::ByteW-1:0];
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (out_load) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    mult_r  <= mult_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    q_r     <= q_nxt;
    rem_r   <= rem_nxt;
    s0_r    <= s0_nxt;
    s1_r    <= s1_nxt;
    prod_r  <= prod_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
    bad_r   <= bad_nxt;
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= res_r;
      out_bad_r  <= bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_bad   = out_bad_r;

endmodule

`default_nettype wire

@@ hdl/multiplicative_byte_cipher_unit.sv @@
// ----------------------------------------------------------------------------
// multiplicative_byte_cipher_unit: byte-wise multiplicative cipher mod m
// Usage:
//   in_*  beats carry a key write (in_tuser[0] = 0) or a data byte (= 1).
//   Key writes fill the key store and give no out beat. Each data byte gives
//   one out beat: the low byte of the byte times the current key byte mod m
//   (encrypt) or of the byte times the key inverse's low byte mod m (decrypt);
//   in decrypt out_tuser flags a nonzero key byte with no inverse. in_tuser[1]
//   restarts the key position at zero. cfg_* writes direction, modulus and
//   key length while the unit is idle.
// Flow:
//   The back end handles one data byte at a time. Encrypt goes through the
//   product, 16 one-bit reduction steps and the output load. Decrypt first
//   runs Euclid division steps, each a one-bit divider over the ten dividend
//   bits plus a test and a coefficient update, then one final test and the
//   encrypt path. Items pass the front end's lookup register and a two-entry
//   queue, which lets key writes and lookups go on while the back end is busy.
// Reset: clears the key position, queue and engine; registers return to
//   encrypt, modulus 257, key length 32. The key store is not cleared.
// Stall: a held out beat stays put; the engine waits, then the queue fills
//   and in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplicative_byte_cipher_unit #(
  parameter int KEY_DEPTH = mbc_pkg::KeyDepthDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [mbc_pkg::InDataW-1:0]       in_tdata,  // key_index, value, pad
  input  wire logic [mbc_pkg::InUserW-1:0]       in_tuser,  // op, first
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [mbc_pkg::OutDataW-1:0]           out_tdata, // result_byte
  output logic [mbc_pkg::OutUserW-1:0]           out_tuser, // not_invertible
  input  wire logic                              cfg_wr_en,
  input  wire logic [mbc_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [mbc_pkg::CfgDataW-1:0]      cfg_wdata
);

  logic                        direction_r;
  logic [mbc_pkg::ModW-1:0]    modulus_r;
  logic [mbc_pkg::LenW-1:0]    key_length_r;
  logic [mbc_pkg::EffModW-1:0] eff_mod;

  logic               q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  mbc_pkg::mbc_item_t q_in_item, q_out_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r  <= mbc_pkg::DirReset;
      modulus_r    <= mbc_pkg::ModReset;
      key_length_r <= mbc_pkg::LenReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mbc_pkg::CFG_DIRECTION:  direction_r  <= cfg_wdata[0];
        mbc_pkg::CFG_MODULUS:    modulus_r    <= cfg_wdata[mbc_pkg::ModW-1:0];
        mbc_pkg::CFG_KEY_LENGTH: key_length_r <= cfg_wdata[mbc_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // a zero modulus acts as 512
  assign eff_mod = (modulus_r == '0) ? mbc_pkg::ModZeroValue
                                     : mbc_pkg::EffModW'(modulus_r);

  mbc_front #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_length   (key_length_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser[0]),
    .in_first     (in_tuser[1]),
    .in_key_index (in_tdata[4:0]),
    .in_value     (in_tdata[12:5]),
    .q_valid      (q_in_valid),
    .q_ready      (q_in_ready),
    .q_item       (q_in_item)
  );

  mbc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_item  (q_in_item),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_item   (q_out_item)
  );

  mbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .direction  (direction_r),
    .eff_mod    (eff_mod),
    .item_valid (q_out_valid),
    .item_ready (q_out_ready),
    .item       (q_out_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_bad    (out_tuser[0])
  );

endmodule

`default_nettype wire
